/* src/egcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, state encoding and controller/datapath interface types for
// the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
  // Euclid on OPERAND_WIDTH-bit operands never takes this many steps
  localparam int STEP_LIMIT    = 2 * OPERAND_WIDTH + 4;
  localparam int STEP_AW       = $clog2(STEP_LIMIT);
  localparam int STEP_W        = $clog2(STEP_LIMIT + 1);
  localparam int BIT_W         = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_STORE,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_SUB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture operands, clear step count
    logic div_init;   // start a division b / a
    logic div_step;   // one restoring step
    logic store;      // save quotient, (a, b) <= (b mod a, a)
    logic back_init;  // x = 0, y = 1, k = steps
    logic back_rd;    // read quotient k-1, decrement k
    logic back_mul;   // product = q * x
    logic back_sub;   // (x, y) <= (y - product, x)
    logic out_load;   // update output register
  } cmd_t;

  typedef struct packed {
    logic a_zero;
    logic div_last;
    logic steps_full;
    logic k_zero;
  } sts_t;

endpackage

/* src/extended_gcd.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd
// Extended Euclid: gcd of two unsigned operands with signed Bezout
// coefficients, one result beat per input beat.
// ----------------------------------------------------------------------------
// One item at a time. The forward pass runs one Euclid step per quotient on
// a bit-serial restoring divider; the quotients go to a small store, then
// back-substitution runs read, multiply and subtract for each step. An item
// waits for its output load while the previous result is still held by a
// stall on the output. An item has at most 45 Euclid steps at
// OPERAND_WIDTH = 31. When the first operand is zero the result is
// divisor = second operand, coef_a = 0, coef_b = 1. The result sits in an
// output register, so the next item is accepted while the previous result
// still waits.
// ----------------------------------------------------------------------------
module extended_gcd (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [egcd_pkg::OPERAND_WIDTH-1:0]     value_a_i,
  input  logic [egcd_pkg::OPERAND_WIDTH-1:0]     value_b_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [egcd_pkg::OPERAND_WIDTH-1:0]     divisor_o,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_a_o,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_b_o
);
  import egcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  egcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  egcd_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .value_a_i(value_a_i),
    .value_b_i(value_b_i),
    .divisor_o(divisor_o),
    .coef_a_o (coef_a_o),
    .coef_b_o (coef_b_o)
  );

endmodule

/* src/egcd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the forward Euclid pass, the back-substitution pass and the
// input/output handshakes.
// ----------------------------------------------------------------------------
module egcd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  egcd_pkg::sts_t sts_i,
  output egcd_pkg::cmd_t cmd_o
);
  import egcd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.a_zero || sts_i.steps_full) begin
          cmd_o.back_init = 1'b1;
          state_d         = ST_BACK_RD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_BACK_RD: begin
        if (sts_i.k_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.back_rd = 1'b1;
          state_d       = ST_BACK_MUL;
        end
      end
      ST_BACK_MUL: begin
        cmd_o.back_mul = 1'b1;
        state_d        = ST_BACK_SUB;
      end
      ST_BACK_SUB: begin
        cmd_o.back_sub = 1'b1;
        state_d        = ST_BACK_RD;
      end
      ST_DONE: begin
        // output register free, or its beat leaves this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/egcd_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_dpath
// Operand registers, bit-serial restoring divider, quotient store and the
// multiply/subtract unit for back-substitution of the coefficients.
// ----------------------------------------------------------------------------
module egcd_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  egcd_pkg::cmd_t                        cmd_i,
  output egcd_pkg::sts_t                        sts_o,
  input  logic [egcd_pkg::OPERAND_WIDTH-1:0]    value_a_i,
  input  logic [egcd_pkg::OPERAND_WIDTH-1:0]    value_b_i,
  output logic [egcd_pkg::OPERAND_WIDTH-1:0]    divisor_o,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_a_o,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coef_b_o
);
  import egcd_pkg::*;

  logic [OPERAND_WIDTH-1:0] a_q, b_q;
  logic [STEP_W-1:0]        steps_q, k_q;
  logic [BIT_W-1:0]         bit_q;
  logic [OPERAND_WIDTH-1:0] rem_q;
  logic [OPERAND_WIDTH-1:0] dvd_q;
  logic [OPERAND_WIDTH-1:0] qmem [STEP_LIMIT];
  logic [OPERAND_WIDTH-1:0] qrd_q;
  logic [COEF_WIDTH-1:0]    x_q, y_q, prod_q;
  logic [OPERAND_WIDTH-1:0] divisor_q;
  logic [COEF_WIDTH-1:0]    coef_a_q, coef_b_q;

  logic [OPERAND_WIDTH:0]   rem_sh;
  logic                     fits;
  logic [STEP_W-1:0]        k_dec;

  // restoring step: shift in next dividend bit, subtract divisor if it fits
  assign rem_sh = {rem_q, dvd_q[OPERAND_WIDTH-1]};
  assign fits   = rem_sh >= {1'b0, a_q};
  assign k_dec  = k_q - STEP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      k_q     <= '0;
      bit_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        steps_q <= '0;
      end else if (cmd_i.store) begin
        steps_q <= steps_q + STEP_W'(1);
      end
      if (cmd_i.div_init) begin
        bit_q <= '0;
      end else if (cmd_i.div_step) begin
        bit_q <= bit_q + BIT_W'(1);
      end
      if (cmd_i.back_init) begin
        k_q <= steps_q;
      end else if (cmd_i.back_rd) begin
        k_q <= k_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= value_a_i;
      b_q <= value_b_i;
    end else if (cmd_i.store) begin
      a_q <= rem_q;
      b_q <= a_q;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dvd_q <= b_q;
    end else if (cmd_i.div_step) begin
      // partial remainder stays below the divisor, so the top bit drops
      rem_q <= fits ? OPERAND_WIDTH'(rem_sh - {1'b0, a_q})
                    : rem_sh[OPERAND_WIDTH-1:0];
      dvd_q <= {dvd_q[OPERAND_WIDTH-2:0], fits};
    end
    if (cmd_i.store) begin
      qmem[steps_q[STEP_AW-1:0]] <= dvd_q;
    end
    if (cmd_i.back_rd) begin
      qrd_q <= qmem[k_dec[STEP_AW-1:0]];
    end
    if (cmd_i.back_init) begin
      x_q <= '0;
      y_q <= COEF_WIDTH'(1);
    end else if (cmd_i.back_sub) begin
      x_q <= y_q - prod_q;
      y_q <= x_q;
    end
    // coefficients wrap modulo 2^COEF_WIDTH
    if (cmd_i.back_mul) begin
      prod_q <= {1'b0, qrd_q} * x_q;
    end
    if (cmd_i.out_load) begin
      divisor_q <= b_q;
      coef_a_q  <= x_q;
      coef_b_q  <= y_q;
    end
  end

  assign sts_o.a_zero     = (a_q == '0);
  assign sts_o.div_last   = (bit_q == BIT_W'(OPERAND_WIDTH - 1));
  assign sts_o.steps_full = (steps_q == STEP_W'(STEP_LIMIT));
  assign sts_o.k_zero     = (k_q == '0);

  assign divisor_o = divisor_q;
  assign coef_a_o  = coef_a_q;
  assign coef_b_o  = coef_b_q;

endmodule

/* tb/extended_gcd_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_test
// Self-checking bench for the extended GCD block. A short table of corner
// operands runs first, then random operand pairs of mixed shape. Both sides
// insert random idle and stall cycles. Every result beat is checked against
// a local Bezout solver, or against the value typed into the table.
// ----------------------------------------------------------------------------
module extended_gcd_test;

  localparam int OW = egcd_pkg::OPERAND_WIDTH;
  localparam int CW = egcd_pkg::COEF_WIDTH;
  localparam logic [OW-1:0] OP_MAX = {OW{1'b1}};
  localparam int RESET_CYCLES = 9;
  localparam int MAX_GAP = 17;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 1700;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OW-1:0]        divisor;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
  } bezout_t;

  typedef struct packed {
    logic [OW-1:0] op_a;
    logic [OW-1:0] op_b;
    logic          known;
    bezout_t       want;
  } vector_t;

  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic signed [CW-1:0] ONE  = 1;
  localparam logic [OW-1:0] FIB_45 = 1134903170;
  localparam logic [OW-1:0] FIB_46 = 1836311903;

  localparam int NUM_VECTORS = 22;
  localparam vector_t CORNER_VECTORS [NUM_VECTORS] = '{
    // first operand zero, including both zero
    '{'0,      '0,      1'b1, '{'0,     ZERO, ONE}},
    '{'0,      OP_MAX,  1'b1, '{OP_MAX, ZERO, ONE}},
    '{'0,      1,       1'b1, '{1,      ZERO, ONE}},
    // second operand zero
    '{OP_MAX,  '0,      1'b1, '{OP_MAX, ONE,  ZERO}},
    '{1,       '0,      1'b1, '{1,      ONE,  ZERO}},
    // equal operands: one step, x = 1
    '{OP_MAX,  OP_MAX,  1'b1, '{OP_MAX, ONE,  ZERO}},
    '{1,       1,       1'b1, '{1,      ONE,  ZERO}},
    '{1,       OP_MAX,  1'b0, '0},
    '{OP_MAX,  1,       1'b0, '0},
    '{2,       OP_MAX,  1'b0, '0},
    // consecutive Fibonacci numbers: longest Euclid chain
    '{FIB_45,  FIB_46,  1'b0, '0},
    '{FIB_46,  FIB_45,  1'b0, '0},
    '{OP_MAX,  OP_MAX - 1, 1'b0, '0},
    '{OP_MAX - 1, OP_MAX, 1'b0, '0},
    '{31'h2AAAAAAA, 31'h55555555, 1'b0, '0},
    '{31'h55555555, 31'h2AAAAAAA, 1'b0, '0},
    '{31'h40000000, 31'h20000000, 1'b0, '0},
    '{31'h40000000, 3,  1'b0, '0},
    '{12,      18,      1'b0, '0},
    '{18,      12,      1'b0, '0},
    '{7,       5,       1'b0, '0},
    '{1000000007, 998244353, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OW-1:0]        value_a_i = '0;
  logic [OW-1:0]        value_b_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OW-1:0]        divisor_o;
  logic signed [CW-1:0] coef_a_o;
  logic signed [CW-1:0] coef_b_o;

  bezout_t     pending_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;

  extended_gcd uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_a_i   (value_a_i),
    .value_b_i   (value_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .divisor_o   (divisor_o),
    .coef_a_o    (coef_a_o),
    .coef_b_o    (coef_b_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Forward Euclid keeping the quotients, then back-substitution from
  // (x, y) = (0, 1); 64-bit wrapping arithmetic, masked to the port width.
  function automatic bezout_t solve_bezout(input logic [OW-1:0] a_in,
                                           input logic [OW-1:0] b_in);
    logic [63:0] rem_a, rem_b, tmp, x, y;
    logic [63:0] quot [egcd_pkg::STEP_LIMIT];
    int          n, k;
    bezout_t     res;
    rem_a = 64'(a_in);
    rem_b = 64'(b_in);
    n = 0;
    while (rem_a != 0 && n < egcd_pkg::STEP_LIMIT) begin
      quot[n] = rem_b / rem_a;
      tmp = rem_b % rem_a;
      rem_b = rem_a;
      rem_a = tmp;
      n++;
    end
    x = 64'd0;
    y = 64'd1;
    for (k = n - 1; k >= 0; k--) begin
      tmp = y - quot[k] * x;
      y = x;
      x = tmp;
    end
    res.divisor = rem_b[OW-1:0];
    res.coef_a = x[CW-1:0];
    res.coef_b = y[CW-1:0];
    return res;
  endfunction

  function automatic logic [OW-1:0] draw_operand();
    logic [OW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1, 2, 3: v = OW'($urandom_range(1, 1000));
      4: v = OP_MAX - OW'($urandom_range(0, 1000));
      5: v = OW'(1) << $urandom_range(0, OW - 1);
      default: v = OW'($urandom);
    endcase
    return v;
  endfunction

  // Drive one operand beat after a random idle gap; keep valid high when the
  // gap is zero so back-to-back beats see a single assignment per step.
  task automatic send_operands(input logic [OW-1:0] a, input logic [OW-1:0] b,
                               input logic known, input bezout_t want);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_a_i <= a;
    value_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(known ? want : solve_bezout(a, b));
  endtask

  initial begin : stimulus
    logic [OW-1:0] a, b;
    logic [63:0]   scaled;
    int unsigned   n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (CORNER_VECTORS[i]) begin
      send_operands(CORNER_VECTORS[i].op_a, CORNER_VECTORS[i].op_b,
                    CORNER_VECTORS[i].known, CORNER_VECTORS[i].want);
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        steady_in = ($urandom_range(0, 3) == 0);
      end
      a = draw_operand();
      b = draw_operand();
      case ($urandom_range(0, 7))
        0: b = a;
        1: begin
          // b an exact multiple of a
          a = OW'($urandom_range(1, 5000));
          scaled = 64'(a) * 64'($urandom_range(0, OP_MAX / a));
          b = scaled[OW-1:0];
        end
        default: ;
      endcase
      send_operands(a, b, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    int unsigned beats;
    bezout_t     got, want;
    beats = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (beats % 32 == 0) begin
        steady_out = ($urandom_range(0, 3) == 0);
      end
      hold = steady_out ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      beats++;
      got.divisor = divisor_o;
      got.coef_a = coef_a_o;
      got.coef_b = coef_b_o;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected result beat: g=%0d x=%0d y=%0d",
                   got.divisor, got.coef_a, got.coef_b);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.divisor !== want.divisor || got.coef_a !== want.coef_a ||
            got.coef_b !== want.coef_b) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch beat %0d: exp g=%0d x=%0d y=%0d, got g=%0d x=%0d y=%0d",
                     beats, want.divisor, want.coef_a, want.coef_b,
                     got.divisor, got.coef_a, got.coef_b);
          end
        end
      end
    end
  end

endmodule
